// ===== src/ioct_pkg.sv =====
// Shared types and codes for the in-order completion tracker.
// No dependencies; used by the controller, the datapath and the top level.
package ioct_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 1'd1;

  localparam logic ACT_ISSUE    = 1'b0;
  localparam logic ACT_COMPLETE = 1'b1;

  localparam logic [1:0] KIND_ISSUED   = 2'd0;
  localparam logic [1:0] KIND_RELEASED = 2'd1;
  localparam logic [1:0] KIND_NONE     = 2'd2;
  localparam logic [1:0] KIND_BYPASS   = 2'd3;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_PART = 2'd1;
  localparam logic [1:0] ERR_FULL     = 2'd2;
  localparam logic [1:0] ERR_WINDOW   = 2'd3;

  localparam logic [3:0] ACTIVE_RESET = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_REL
  } ioct_state_t;

  typedef struct packed {
    logic capture;
    logic eval_emit;
    logic rel_start;
    logic rel_emit;
  } ioct_cmd_t;

  typedef struct packed {
    logic eval_release;
    logic rel_more;
  } ioct_sts_t;

endpackage

// ===== src/ioct_ctrl.sv =====
// Sequencing controller for the in-order completion tracker.
// Depends on ioct_pkg; drives the datapath through ioct_cmd_t.
module ioct_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  output logic                  result_valid,
  input  logic                  result_ready,
  input  ioct_pkg::ioct_sts_t   sts,
  output ioct_pkg::ioct_cmd_t   cmd
);

  ioct_pkg::ioct_state_t state, state_next;
  logic out_free;
  logic out_load;

  assign out_free = !result_valid || result_ready;
  assign out_load = cmd.eval_emit || cmd.rel_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ioct_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next    = state;
    item_ready    = 1'b0;
    cmd           = '0;
    unique case (state)
      ioct_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = ioct_pkg::ST_EVAL;
        end
      end
      ioct_pkg::ST_EVAL: begin
        if (sts.eval_release) begin
          cmd.rel_start = 1'b1;
          state_next    = ioct_pkg::ST_REL;
        end else if (out_free) begin
          cmd.eval_emit = 1'b1;
          state_next    = ioct_pkg::ST_IDLE;
        end
      end
      ioct_pkg::ST_REL: begin
        if (out_free) begin
          cmd.rel_emit = 1'b1;
          if (!sts.rel_more) begin
            state_next = ioct_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ioct_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/ioct_dpath.sv =====
// Datapath: config registers, per-partition state memory, window checks,
// release shifter and result register. Depends on ioct_pkg.
module ioct_dpath #(
  parameter int PARTITIONS = 8,
  parameter int WINDOW     = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [ioct_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ioct_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 action,
  input  logic [2:0]                           partition,
  input  logic [31:0]                          seq_in,
  input  logic                                 write_ok,
  input  logic                                 wants_notice,
  input  ioct_pkg::ioct_cmd_t                  cmd,
  output ioct_pkg::ioct_sts_t                  sts,
  output logic [1:0]                           kind,
  output logic [2:0]                           out_partition,
  output logic [31:0]                          seq_out,
  output logic                                 ok,
  output logic                                 notice,
  output logic [1:0]                           error,
  output logic                                 last
);

  localparam int PIDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int VLD_N  = 1 << PIDX_W;
  localparam int OFF_W  = $clog2(WINDOW);
  localparam int OW     = $clog2(WINDOW + 1);
  localparam int ENT_W  = 64 + 3 * WINDOW;

  logic             enabled;
  logic [3:0]       active;

  logic             cap_action;
  logic [2:0]       cap_part;
  logic [31:0]      cap_seq;
  logic             cap_wok;
  logic             cap_wn;
  logic [PIDX_W-1:0] cap_idx;

  logic [ENT_W-1:0] state_mem [PARTITIONS];
  logic [ENT_W-1:0] rd_data;
  logic [VLD_N-1:0] vld;
  logic [ENT_W-1:0] ent;

  logic [31:0]       r_iss, r_rel;
  logic [WINDOW-1:0] r_done, r_outc, r_note;
  logic [31:0]       outs32, off32;
  logic              bad, full, oob, dup;
  logic [OFF_W-1:0]  bit_idx;
  logic [WINDOW-1:0] bsel;

  logic [1:0]        e_kind, e_err;
  logic [31:0]       e_seq;
  logic              e_ok, e_note, e_wr, e_rel;
  logic [31:0]       n_iss;
  logic [WINDOW-1:0] n_done, n_outc, n_note;

  logic [31:0]       w_iss, w_rel;
  logic [OW-1:0]     w_outs;
  logic [WINDOW-1:0] w_done, w_outc, w_note;
  logic [31:0]       s_rel;
  logic [OW-1:0]     s_outs;
  logic [WINDOW-1:0] s_done, s_outc, s_note;
  logic              rel_more;

  logic              wr_en;
  logic [ENT_W-1:0]  wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
      active  <= ioct_pkg::ACTIVE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ioct_pkg::CFG_ENABLED: enabled <= cfg_data[0];
        ioct_pkg::CFG_ACTIVE:  active  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_action <= action;
      cap_part   <= partition;
      cap_seq    <= seq_in;
      cap_wok    <= write_ok;
      cap_wn     <= wants_notice;
      rd_data    <= state_mem[PIDX_W'(partition)];
    end
    if (wr_en) begin
      state_mem[cap_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[cap_idx] <= 1'b1;
    end
  end

  assign cap_idx = PIDX_W'(cap_part);
  assign ent     = vld[cap_idx] ? rd_data : '0;
  assign r_iss   = ent[ENT_W-1 -: 32];
  assign r_rel   = ent[ENT_W-33 -: 32];
  assign r_done  = ent[3*WINDOW-1 -: WINDOW];
  assign r_outc  = ent[2*WINDOW-1 -: WINDOW];
  assign r_note  = ent[WINDOW-1:0];

  assign outs32  = r_iss - r_rel;
  assign off32   = cap_seq - r_rel;
  assign bad     = (4'(cap_part) >= active) || (32'(cap_part) >= 32'(PARTITIONS));
  assign full    = outs32 >= 32'(WINDOW);
  assign oob     = (off32 >= outs32) || (off32 >= 32'(WINDOW));
  assign bit_idx = (cap_action == ioct_pkg::ACT_ISSUE) ? outs32[OFF_W-1:0] : off32[OFF_W-1:0];
  assign bsel    = WINDOW'(1) << bit_idx;
  assign dup     = |(r_done & bsel);

  always_comb begin
    e_kind = ioct_pkg::KIND_NONE;
    e_seq  = cap_seq;
    e_ok   = 1'b0;
    e_note = 1'b0;
    e_err  = ioct_pkg::ERR_NONE;
    e_wr   = 1'b0;
    e_rel  = 1'b0;
    n_iss  = r_iss;
    n_done = r_done;
    n_outc = r_outc;
    n_note = r_note;
    if (!enabled) begin
      if (cap_action == ioct_pkg::ACT_ISSUE) begin
        e_kind = ioct_pkg::KIND_BYPASS;
        e_seq  = '0;
        e_ok   = 1'b1;
        e_note = cap_wn;
      end
    end else if (bad) begin
      e_err = ioct_pkg::ERR_BAD_PART;
      if (cap_action == ioct_pkg::ACT_ISSUE) begin
        e_kind = ioct_pkg::KIND_ISSUED;
        e_seq  = '0;
      end
    end else if (cap_action == ioct_pkg::ACT_ISSUE) begin
      e_kind = ioct_pkg::KIND_ISSUED;
      if (full) begin
        e_seq = '0;
        e_err = ioct_pkg::ERR_FULL;
      end else begin
        e_seq  = r_iss;
        e_ok   = 1'b1;
        e_wr   = 1'b1;
        n_iss  = r_iss + 32'd1;
        n_done = r_done & ~bsel;
        n_outc = r_outc & ~bsel;
        n_note = cap_wn ? (r_note | bsel) : (r_note & ~bsel);
      end
    end else if (oob || dup) begin
      e_err = ioct_pkg::ERR_WINDOW;
    end else begin
      n_done = r_done | bsel;
      n_outc = cap_wok ? (r_outc | bsel) : (r_outc & ~bsel);
      if (n_done[0]) begin
        e_rel = 1'b1;
      end else begin
        e_ok = 1'b1;
        e_wr = 1'b1;
      end
    end
  end

  // release run: one in-order entry per beat
  assign rel_more = w_done[1] && (w_outs > OW'(1));
  assign s_done   = w_done >> 1;
  assign s_outc   = w_outc >> 1;
  assign s_note   = w_note >> 1;
  assign s_rel    = w_rel + 32'd1;
  assign s_outs   = w_outs - OW'(1);

  always_ff @(posedge clk) begin
    if (cmd.rel_start) begin
      w_iss  <= r_iss;
      w_rel  <= r_rel;
      w_outs <= OW'(outs32);
      w_done <= n_done;
      w_outc <= n_outc;
      w_note <= n_note;
    end else if (cmd.rel_emit) begin
      w_rel  <= s_rel;
      w_outs <= s_outs;
      w_done <= s_done;
      w_outc <= s_outc;
      w_note <= s_note;
    end
  end

  assign wr_en   = (cmd.eval_emit && e_wr) || (cmd.rel_emit && !rel_more);
  assign wr_data = cmd.rel_emit ? {w_iss, s_rel, s_done, s_outc, s_note}
                                : {n_iss, r_rel, n_done, n_outc, n_note};

  assign sts.eval_release = e_rel;
  assign sts.rel_more     = rel_more;

  always_ff @(posedge clk) begin
    if (cmd.eval_emit) begin
      kind          <= e_kind;
      out_partition <= cap_part;
      seq_out       <= e_seq;
      ok            <= e_ok;
      notice        <= e_note;
      error         <= e_err;
      last          <= 1'b1;
    end else if (cmd.rel_emit) begin
      kind          <= ioct_pkg::KIND_RELEASED;
      out_partition <= cap_part;
      seq_out       <= w_rel;
      ok            <= w_outc[0];
      notice        <= w_note[0];
      error         <= ioct_pkg::ERR_NONE;
      last          <= !rel_more;
    end
  end

endmodule

// ===== src/in_order_completion_tracker_core.sv =====
// Top level of the in-order completion tracker: controller plus datapath.
// Depends on ioct_pkg, ioct_ctrl and ioct_dpath.
//
// Item channel (item_valid/item_ready): an issue asks for the partition's
// next sequence number; a completion marks seq_in done and releases every
// consecutive done sequence from the partition's release point in order.
// Result channel (result_valid/result_ready): one beat per result, last set
// on the final beat caused by an item. Config channel (cfg_valid/cfg_ready,
// always ready): index 0 enable, index 1 active partition count.
// Timing: one item at a time. An item is read from the state memory in the
// cycle after acceptance. Issues and non-releasing completions register a single
// result once the result register is free; a completion releasing n entries
// gives n beats, one per cycle through the release shifter while the receiver
// is not stalling. The state memory port is read once and written at most once
// per item. When the receiver stalls, the block holds its result and waits.
// Reset: synchronous; clears enable, sets active count 8, clears per-partition
// valid bits, so every partition reads as all zero with no clearing pass.
module in_order_completion_tracker_core #(
  parameter int PARTITIONS = 8,
  parameter int WINDOW     = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ioct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ioct_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  logic                             action,
  input  logic [2:0]                       partition,
  input  logic [31:0]                      seq_in,
  input  logic                             write_ok,
  input  logic                             wants_notice,
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic [1:0]                       kind,
  output logic [2:0]                       out_partition,
  output logic [31:0]                      seq_out,
  output logic                             ok,
  output logic                             notice,
  output logic [1:0]                       error,
  output logic                             last
);

  ioct_pkg::ioct_cmd_t cmd;
  ioct_pkg::ioct_sts_t sts;

  assign cfg_ready = 1'b1;

  ioct_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  ioct_dpath #(
    .PARTITIONS (PARTITIONS),
    .WINDOW     (WINDOW)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (action),
    .partition     (partition),
    .seq_in        (seq_in),
    .write_ok      (write_ok),
    .wants_notice  (wants_notice),
    .cmd           (cmd),
    .sts           (sts),
    .kind          (kind),
    .out_partition (out_partition),
    .seq_out       (seq_out),
    .ok            (ok),
    .notice        (notice),
    .error         (error),
    .last          (last)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("item accepted while previous item still in flight");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.eval_emit || cmd.rel_emit) |=> result_valid)
    else $error("result loaded but not presented");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.rel_emit && !sts.rel_more) |=> (item_ready && last))
    else $error("release run did not end cleanly");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.rel_start |=> !item_ready)
    else $error("input taken during release run");

endmodule
